/* design/bmp_region_rgb_gain_core_assert.svh */
// Assertion macros for the BMP region gain core.
// Each macro names a clocked property on clock, disabled while reset is high.
`ifndef BMP_REGION_RGB_GAIN_CORE_ASSERT_SVH
`define BMP_REGION_RGB_GAIN_CORE_ASSERT_SVH

// Same-cycle implication.
`define BRG_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BRG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/brg_pkg.sv */
`default_nettype none

package brg_pkg;

   // Image limits and header layout.
   localparam int MAX_DIM      = 4096;
   localparam int HEADER_BYTES = 54;
   localparam int DIM_W        = $clog2(MAX_DIM + 1);
   localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
   localparam int OFS_WIDTH    = 18;
   localparam int OFS_HEIGHT   = 22;
   localparam int OFS_DEPTH    = 28;
   localparam int FIELD_BYTES  = 4;
   localparam int DEPTH_BYTES  = 2;
   localparam int BMP_DEPTH    = 24;

   localparam logic [HDR_IDX_W-1:0] HEADER_LAST = HDR_IDX_W'(HEADER_BYTES - 1);
   localparam logic [HDR_IDX_W-1:0] IDX_WIDTH_LO  = HDR_IDX_W'(OFS_WIDTH);
   localparam logic [HDR_IDX_W-1:0] IDX_WIDTH_HI  = HDR_IDX_W'(OFS_WIDTH + FIELD_BYTES - 1);
   localparam logic [HDR_IDX_W-1:0] IDX_HEIGHT_LO = HDR_IDX_W'(OFS_HEIGHT);
   localparam logic [HDR_IDX_W-1:0] IDX_HEIGHT_HI = HDR_IDX_W'(OFS_HEIGHT + FIELD_BYTES - 1);
   localparam logic [HDR_IDX_W-1:0] IDX_DEPTH_LO  = HDR_IDX_W'(OFS_DEPTH);
   localparam logic [HDR_IDX_W-1:0] IDX_DEPTH_HI  = HDR_IDX_W'(OFS_DEPTH + DEPTH_BYTES - 1);
   localparam logic [31:0] DIM_LIM = 32'(MAX_DIM);
   localparam logic [15:0] DEPTH_OK = 16'(BMP_DEPTH);

   // Configuration registers.
   localparam int RECT_W     = 13;
   localparam int GAIN_W     = 16;
   localparam int CSR_W      = GAIN_W;
   localparam int REG_IDX_W  = 3;
   localparam int RECT_MAX   = 4095;
   localparam int GAIN_UNITY = 256;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_RECT_LEFT   = 3'd0,
      REG_RECT_TOP    = 3'd1,
      REG_RECT_RIGHT  = 3'd2,
      REG_RECT_BOTTOM = 3'd3,
      REG_GAIN_RED    = 3'd4,
      REG_GAIN_GREEN  = 3'd5,
      REG_GAIN_BLUE   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [RECT_W-1:0] rect_left;
      logic signed [RECT_W-1:0] rect_top;
      logic signed [RECT_W-1:0] rect_right;
      logic signed [RECT_W-1:0] rect_bottom;
      logic signed [GAIN_W-1:0] gain_red;
      logic signed [GAIN_W-1:0] gain_green;
      logic signed [GAIN_W-1:0] gain_blue;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rect_left:   RECT_W'(0),
      rect_top:    RECT_W'(0),
      rect_right:  RECT_W'(RECT_MAX),
      rect_bottom: RECT_W'(RECT_MAX),
      gain_red:    GAIN_W'(GAIN_UNITY),
      gain_green:  GAIN_W'(GAIN_UNITY),
      gain_blue:   GAIN_W'(GAIN_UNITY)
   };

   // Commands from the front end to the back end.
   typedef enum logic [2:0] {
      CMD_STORE,
      CMD_BURST,
      CMD_ERROR,
      CMD_PASS,
      CMD_GAIN
   } cmd_kind_type;

   typedef enum logic [1:0] {
      CH_BLUE,
      CH_GREEN,
      CH_RED
   } chan_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [7:0]            data;
      logic [HDR_IDX_W-1:0]  hidx;
      chan_type              chan;
   } cmd_type;

   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

endpackage

`default_nettype wire

/* design/brg_front.sv */
`default_nettype none

// Front end: collects the header, checks the format and tags every
// image byte with its channel and whether it lies in the region.
module brg_front (
   input  wire                logic clock,
   input  wire                logic reset,
   input  brg_pkg::cfg_type   cfg,
   input  wire                logic push,
   input  wire                logic [7:0] in_byte,
   input  wire                logic file_end,
   input  wire                logic cmd_full,
   output logic               cmd_push,
   output brg_pkg::cmd_type   cmd
);

   localparam int CMP_W = ((brg_pkg::DIM_W > brg_pkg::RECT_W) ?
                           brg_pkg::DIM_W : brg_pkg::RECT_W) + 2;
   localparam logic signed [CMP_W-1:0] ONE_S = CMP_W'(1);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXEL,
      PH_TRAIL,
      PH_DROP
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [brg_pkg::HDR_IDX_W-1:0]   hidx_ff, hidx_in;
   logic [31:0]                     wid_raw_ff, wid_raw_in;
   logic [31:0]                     hgt_raw_ff, hgt_raw_in;
   logic [15:0]                     bpp_ff, bpp_in;
   logic [brg_pkg::DIM_W-1:0]       img_w_ff, img_w_in;
   logic [brg_pkg::DIM_W-1:0]       abs_h_ff, abs_h_in;
   logic                            bottom_up_ff, bottom_up_in;
   logic [brg_pkg::DIM_W-1:0]       col_ff, col_in;
   logic [brg_pkg::DIM_W-1:0]       row_ff, row_in;
   brg_pkg::chan_type               chan_ff, chan_in;
   logic [1:0]                      pad_ff, pad_in;

   logic                            accept;
   logic                            hdr_ok;
   logic [31:0]                     habs;
   logic                            row_step;
   logic [brg_pkg::DIM_W-1:0]       col_inc;
   logic [brg_pkg::DIM_W-1:0]       row_inc;
   logic signed [CMP_W-1:0]         x1, x2, y1, y2, w_s, h_s, ay, col_s, row_s;
   logic signed [CMP_W-1:0]         left_s, top_s, right_s, bottom_s;
   logic                            in_rect;
   brg_pkg::chan_type               chan_next;

   // Header checks, evaluated while the last header byte arrives.
   always_comb begin
      habs   = hgt_raw_ff[31] ? (~hgt_raw_ff + 32'd1) : hgt_raw_ff;
      hdr_ok = (bpp_ff == brg_pkg::DEPTH_OK) &&
               !wid_raw_ff[31] && (wid_raw_ff <= brg_pkg::DIM_LIM) &&
               ($signed(hgt_raw_ff) <= $signed(brg_pkg::DIM_LIM)) &&
               ($signed(hgt_raw_ff) >= -$signed(brg_pkg::DIM_LIM));
   end

   // Region test against the clamped rectangle.
   always_comb begin
      left_s   = CMP_W'(cfg.rect_left);
      top_s    = CMP_W'(cfg.rect_top);
      right_s  = CMP_W'(cfg.rect_right);
      bottom_s = CMP_W'(cfg.rect_bottom);
      w_s      = CMP_W'(img_w_ff);
      h_s      = CMP_W'(abs_h_ff);
      col_s    = CMP_W'(col_ff);
      row_s    = CMP_W'(row_ff);
      x1       = (left_s < 0) ? '0 : left_s;
      y1       = (top_s < 0) ? '0 : top_s;
      x2       = (right_s >= w_s) ? (w_s - ONE_S) : right_s;
      y2       = (bottom_s >= h_s) ? (h_s - ONE_S) : bottom_s;
      ay       = bottom_up_ff ? (h_s - ONE_S - row_s) : row_s;
      in_rect  = (col_s >= x1) && (col_s <= x2) && (ay >= y1) && (ay <= y2);
   end

   always_comb begin
      case (chan_ff)
         brg_pkg::CH_BLUE:  chan_next = brg_pkg::CH_GREEN;
         brg_pkg::CH_GREEN: chan_next = brg_pkg::CH_RED;
         default:           chan_next = brg_pkg::CH_BLUE;
      endcase
   end

   assign accept  = push && !cmd_full;
   assign col_inc = col_ff + brg_pkg::DIM_W'(1);
   assign row_inc = row_ff + brg_pkg::DIM_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      hidx_in      = hidx_ff;
      wid_raw_in   = wid_raw_ff;
      hgt_raw_in   = hgt_raw_ff;
      bpp_in       = bpp_ff;
      img_w_in     = img_w_ff;
      abs_h_in     = abs_h_ff;
      bottom_up_in = bottom_up_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      chan_in      = chan_ff;
      pad_in       = pad_ff;
      row_step     = 1'b0;
      cmd_push     = 1'b0;
      cmd.kind     = brg_pkg::CMD_PASS;
      cmd.data     = in_byte;
      cmd.hidx     = hidx_ff;
      cmd.chan     = chan_ff;

      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               // The size and depth fields are little endian; shift each byte in from the top.
               if (hidx_ff >= brg_pkg::IDX_WIDTH_LO && hidx_ff <= brg_pkg::IDX_WIDTH_HI) begin
                  wid_raw_in = {in_byte, wid_raw_ff[31:8]};
               end
               if (hidx_ff >= brg_pkg::IDX_HEIGHT_LO && hidx_ff <= brg_pkg::IDX_HEIGHT_HI) begin
                  hgt_raw_in = {in_byte, hgt_raw_ff[31:8]};
               end
               if (hidx_ff >= brg_pkg::IDX_DEPTH_LO && hidx_ff <= brg_pkg::IDX_DEPTH_HI) begin
                  bpp_in = {in_byte, bpp_ff[15:8]};
               end

               if (hidx_ff == brg_pkg::HEADER_LAST) begin
                  hidx_in  = '0;
                  cmd_push = 1'b1;
                  if (hdr_ok) begin
                     cmd.kind     = brg_pkg::CMD_BURST;
                     img_w_in     = wid_raw_ff[brg_pkg::DIM_W-1:0];
                     abs_h_in     = habs[brg_pkg::DIM_W-1:0];
                     bottom_up_in = !hgt_raw_ff[31];
                     col_in       = '0;
                     row_in       = '0;
                     chan_in      = brg_pkg::CH_BLUE;
                     pad_in       = '0;
                     phase_in     = ((wid_raw_ff == '0) || (hgt_raw_ff == '0)) ?
                                    PH_TRAIL : PH_PIXEL;
                  end else begin
                     cmd.kind = brg_pkg::CMD_ERROR;
                     phase_in = PH_DROP;
                  end
               end else if (file_end) begin
                  // The file ended inside its header.
                  cmd_push = 1'b1;
                  cmd.kind = brg_pkg::CMD_ERROR;
               end else begin
                  cmd_push = 1'b1;
                  cmd.kind = brg_pkg::CMD_STORE;
                  hidx_in  = hidx_ff + brg_pkg::HDR_IDX_W'(1);
               end
            end

            PH_PIXEL: begin
               cmd_push = 1'b1;
               if (pad_ff != 2'd0) begin
                  pad_in = pad_ff - 2'd1;
                  if (pad_ff == 2'd1) begin
                     row_step = 1'b1;
                  end
               end else begin
                  cmd.kind = in_rect ? brg_pkg::CMD_GAIN : brg_pkg::CMD_PASS;
                  if (chan_ff == brg_pkg::CH_RED) begin
                     chan_in = brg_pkg::CH_BLUE;
                     col_in  = col_inc;
                     if (col_inc == img_w_ff) begin
                        // Three bytes per pixel: the row pads by width mod 4 bytes.
                        pad_in = img_w_ff[1:0];
                        if (img_w_ff[1:0] == 2'd0) begin
                           row_step = 1'b1;
                        end
                     end
                  end else begin
                     chan_in = chan_next;
                  end
               end
            end

            PH_TRAIL: begin
               cmd_push = 1'b1;
            end

            default: begin
            end
         endcase

         if (row_step) begin
            col_in  = '0;
            chan_in = brg_pkg::CH_BLUE;
            row_in  = row_inc;
            if (row_inc == abs_h_ff) begin
               phase_in = PH_TRAIL;
            end
         end

         if (file_end) begin
            phase_in = PH_HEADER;
            hidx_in  = '0;
            pad_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hidx_ff      <= '0;
         img_w_ff     <= '0;
         abs_h_ff     <= '0;
         bottom_up_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         chan_ff      <= brg_pkg::CH_BLUE;
         pad_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         hidx_ff      <= hidx_in;
         wid_raw_ff   <= wid_raw_in;
         hgt_raw_ff   <= hgt_raw_in;
         bpp_ff       <= bpp_in;
         img_w_ff     <= img_w_in;
         abs_h_ff     <= abs_h_in;
         bottom_up_ff <= bottom_up_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         chan_ff      <= chan_in;
         pad_ff       <= pad_in;
      end
   end

endmodule

`default_nettype wire

/* design/brg_cmd_fifo.sv */
`default_nettype none

// Small command queue between the front end and the back end.
module brg_cmd_fifo (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic push,
   input  brg_pkg::cmd_type   push_cmd,
   output logic               full,
   input  wire                logic pop,
   output brg_pkg::cmd_type   pop_cmd,
   output logic               valid
);

   localparam int PTR_W = $clog2(brg_pkg::CMD_DEPTH);
   localparam int CNT_W = $clog2(brg_pkg::CMD_DEPTH + 1);

   brg_pkg::cmd_type    slot_ff [brg_pkg::CMD_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(brg_pkg::CMD_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? (wr_ptr_ff + PTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? (rd_ptr_ff + PTR_W'(1)) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

/* design/brg_back.sv */
`default_nettype none

// Back end: header RAM and burst replay, gain multiply with saturation,
// and the result queue.
module brg_back (
   input  wire                logic clock,
   input  wire                logic reset,
   input  brg_pkg::cfg_type   cfg,
   input  wire                logic cmd_valid,
   input  brg_pkg::cmd_type   cmd,
   output logic               cmd_pop,
   input  wire                logic res_pop,
   output logic               res_empty,
   output logic [7:0]         res_byte,
   output logic               res_last,
   output logic               res_err
);

   localparam int PROD_W = 8 + 1 + brg_pkg::GAIN_W;
   localparam int OQ_PTR_W = $clog2(brg_pkg::OUT_DEPTH);
   localparam int OQ_CNT_W = $clog2(brg_pkg::OUT_DEPTH + 1);

   typedef enum logic {
      BK_RUN,
      BK_BURST
   } bk_state_type;

   typedef enum logic [1:0] {
      RK_RAW,
      RK_HDR,
      RK_GAIN,
      RK_ERR
   } res_kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } res_type;

   bk_state_type                    state_ff, state_in;
   logic [brg_pkg::HDR_IDX_W-1:0]   bidx_ff, bidx_in;
   logic                            s1_valid_ff, s1_valid_in;
   res_kind_type                    s1_kind_ff, s1_kind_in;
   logic [7:0]                      s1_data_ff, s1_data_in;
   logic                            s1_last_ff, s1_last_in;
   logic signed [PROD_W-1:0]        s1_prod_ff, s1_prod_in;

   logic [7:0]                      hdr_mem [brg_pkg::HEADER_BYTES];
   logic [7:0]                      mem_q_ff;
   logic                            mem_we, mem_re;
   logic [brg_pkg::HDR_IDX_W-1:0]   mem_waddr;

   res_type                         oq_ff [brg_pkg::OUT_DEPTH];
   logic [OQ_PTR_W-1:0]             oq_wr_ff, oq_wr_in;
   logic [OQ_PTR_W-1:0]             oq_rd_ff, oq_rd_in;
   logic [OQ_CNT_W-1:0]             oq_cnt_ff, oq_cnt_in;
   logic [OQ_CNT_W:0]               occupancy;
   logic                            room;
   logic                            oq_pop;
   logic signed [brg_pkg::GAIN_W-1:0] gain_sel;
   res_type                         res;

   // A slot must be free for the result already in the pipeline stage.
   assign occupancy = (OQ_CNT_W + 1)'(oq_cnt_ff) + (OQ_CNT_W + 1)'(s1_valid_ff);
   assign room      = occupancy < (OQ_CNT_W + 1)'(brg_pkg::OUT_DEPTH);

   always_comb begin
      case (cmd.chan)
         brg_pkg::CH_GREEN: gain_sel = cfg.gain_green;
         brg_pkg::CH_RED:   gain_sel = cfg.gain_red;
         default:           gain_sel = cfg.gain_blue;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      bidx_in     = bidx_ff;
      s1_valid_in = 1'b0;
      s1_kind_in  = s1_kind_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = 1'b1;
      s1_prod_in  = s1_prod_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = cmd.hidx;

      case (state_ff)
         BK_RUN: begin
            if (room && cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  brg_pkg::CMD_STORE: begin
                     mem_we = 1'b1;
                  end
                  brg_pkg::CMD_BURST: begin
                     mem_we    = 1'b1;
                     mem_waddr = brg_pkg::HEADER_LAST;
                     bidx_in   = '0;
                     state_in  = BK_BURST;
                  end
                  brg_pkg::CMD_ERROR: begin
                     s1_valid_in = 1'b1;
                     s1_kind_in  = RK_ERR;
                  end
                  brg_pkg::CMD_GAIN: begin
                     s1_valid_in = 1'b1;
                     s1_kind_in  = RK_GAIN;
                     s1_prod_in  = PROD_W'($signed({1'b0, cmd.data})) * PROD_W'(gain_sel);
                  end
                  default: begin
                     s1_valid_in = 1'b1;
                     s1_kind_in  = RK_RAW;
                     s1_data_in  = cmd.data;
                  end
               endcase
            end
         end

         BK_BURST: begin
            if (room) begin
               mem_re      = 1'b1;
               s1_valid_in = 1'b1;
               s1_kind_in  = RK_HDR;
               s1_last_in  = (bidx_ff == brg_pkg::HEADER_LAST);
               bidx_in     = bidx_ff + brg_pkg::HDR_IDX_W'(1);
               if (bidx_ff == brg_pkg::HEADER_LAST) begin
                  state_in = BK_RUN;
               end
            end
         end

         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   // Header RAM: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hdr_mem[mem_waddr] <= cmd.data;
      end
      if (mem_re) begin
         mem_q_ff <= hdr_mem[bidx_ff];
      end
   end

   // Result formation: truncate the Q8.8 product and saturate to a byte.
   always_comb begin
      res.data = s1_data_ff;
      res.last = s1_last_ff;
      res.err  = 1'b0;
      case (s1_kind_ff)
         RK_HDR: begin
            res.data = mem_q_ff;
         end
         RK_GAIN: begin
            if (s1_prod_ff[PROD_W-1]) begin
               res.data = 8'd0;
            end else if (|s1_prod_ff[PROD_W-2:16]) begin
               res.data = 8'hff;
            end else begin
               res.data = s1_prod_ff[15:8];
            end
         end
         RK_ERR: begin
            res.data = 8'd0;
            res.err  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign oq_pop    = res_pop && (oq_cnt_ff != '0);
   assign res_empty = (oq_cnt_ff == '0);
   assign res_byte  = oq_ff[oq_rd_ff].data;
   assign res_last  = oq_ff[oq_rd_ff].last;
   assign res_err   = oq_ff[oq_rd_ff].err;

   always_comb begin
      oq_wr_in  = s1_valid_ff ? (oq_wr_ff + OQ_PTR_W'(1)) : oq_wr_ff;
      oq_rd_in  = oq_pop ? (oq_rd_ff + OQ_PTR_W'(1)) : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + OQ_CNT_W'(s1_valid_ff) - OQ_CNT_W'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         oq_ff[oq_wr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_RUN;
         bidx_ff     <= '0;
         s1_valid_ff <= 1'b0;
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_cnt_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         bidx_ff     <= bidx_in;
         s1_valid_ff <= s1_valid_in;
         s1_kind_ff  <= s1_kind_in;
         s1_data_ff  <= s1_data_in;
         s1_last_ff  <= s1_last_in;
         s1_prod_ff  <= s1_prod_in;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_cnt_ff   <= oq_cnt_in;
      end
   end

endmodule

`default_nettype wire

/* design/bmp_region_rgb_gain_core.sv */
`default_nettype none

// Per-channel gain on a rectangle of a 24-bit BMP byte stream. The file enters one byte
// per item on the request queue; the last byte of a file is marked with file_end. The
// first 53 header bytes give no result; the 54th gives the whole 54-byte header as a
// burst of results (run_last on the last one), or a single result with format_error set
// and a zero byte when the depth is not 24 or the width or height is out of range, after
// which the rest of that file is dropped. A file that ends inside its header also gives
// one error result. Pixel bytes inside the clamped rectangle are scaled by the signed
// Q8.8 gain of their channel, truncated and saturated to 0..255; row padding and bytes
// past the image pass through unchanged. Throughput is one byte per cycle through the
// image and the trailer while results are popped. The header burst is replayed from
// the header RAM at one byte per cycle while the result queue has room; the four-entry
// command queue keeps accepting the following bytes during that time until it fills.
// A pixel byte is registered in the command queue, the s1 stage and the result
// queue. The region and gain registers are written through the csr port and are meant
// to change only while the block is idle; a write to index seven is ignored.
module bmp_region_rgb_gain_core (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          push,
   output logic                               full,
   input  wire logic [7:0]                    req_in_byte,
   input  wire logic                          req_file_end,

   output logic                               empty,
   input  wire logic                          pop,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_run_last,
   output logic                               rsp_format_error,

   input  wire logic                          csr_we,
   input  wire logic [brg_pkg::REG_IDX_W-1:0] csr_addr,
   input  wire logic [brg_pkg::CSR_W-1:0]     csr_wdata
);

`include "bmp_region_rgb_gain_core_assert.svh"

   brg_pkg::cfg_type  cfg_ff, cfg_in;
   brg_pkg::cmd_type  front_cmd;
   brg_pkg::cmd_type  queue_cmd;
   logic              cmd_push;
   logic              cmd_full;
   logic              cmd_valid;
   logic              cmd_pop;

   // Configuration registers: a plain write with no wait state.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            brg_pkg::REG_RECT_LEFT:   cfg_in.rect_left   = csr_wdata[brg_pkg::RECT_W-1:0];
            brg_pkg::REG_RECT_TOP:    cfg_in.rect_top    = csr_wdata[brg_pkg::RECT_W-1:0];
            brg_pkg::REG_RECT_RIGHT:  cfg_in.rect_right  = csr_wdata[brg_pkg::RECT_W-1:0];
            brg_pkg::REG_RECT_BOTTOM: cfg_in.rect_bottom = csr_wdata[brg_pkg::RECT_W-1:0];
            brg_pkg::REG_GAIN_RED:    cfg_in.gain_red    = csr_wdata[brg_pkg::GAIN_W-1:0];
            brg_pkg::REG_GAIN_GREEN:  cfg_in.gain_green  = csr_wdata[brg_pkg::GAIN_W-1:0];
            brg_pkg::REG_GAIN_BLUE:   cfg_in.gain_blue   = csr_wdata[brg_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= brg_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The request side is full exactly when the command queue is.
   assign full = cmd_full;

   brg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .in_byte  (req_in_byte),
      .file_end (req_file_end),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (front_cmd)
   );

   brg_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_cmd  (queue_cmd),
      .valid    (cmd_valid)
   );

   brg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (queue_cmd),
      .cmd_pop   (cmd_pop),
      .res_pop   (pop),
      .res_empty (empty),
      .res_byte  (rsp_out_byte),
      .res_last  (rsp_run_last),
      .res_err   (rsp_format_error)
   );

   // The front end only issues a command when the queue has room for it.
   `BRG_ASSERT_IMP(a_cmd_no_overflow, cmd_push, !cmd_full, "command issued into a full queue")

   // An error result carries a zero byte and closes its run.
   `BRG_ASSERT_IMP(a_err_result_shape, !empty && rsp_format_error,
                   rsp_out_byte == 8'd0 && rsp_run_last, "malformed error result")

   // A command written into an empty queue is visible to the back end next cycle.
   `BRG_ASSERT_NEXT(a_cmd_visible, cmd_push && !cmd_valid, cmd_valid,
                    "queued command not visible to the back end")

endmodule

`default_nettype wire

/* verif/bmp_region_rgb_gain_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Watches both queues and the csr port of the BMP region gain core, keeps its own
// copy of the stream state, and compares every popped item with the oldest one it
// predicted.
module bmp_region_rgb_gain_checker
   import brg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic                 full,
   input  wire logic [7:0]           req_in_byte,
   input  wire logic                 req_file_end,
   input  wire logic                 empty,
   input  wire logic                 pop,
   input  wire logic [7:0]           rsp_out_byte,
   input  wire logic                 rsp_run_last,
   input  wire logic                 rsp_format_error,
   input  wire logic                 csr_we,
   input  wire logic [REG_IDX_W-1:0] csr_addr,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   output int                        fail_count,
   output int                        pending_count
);

   typedef enum logic [1:0] {
      ST_HEADER,
      ST_PIXEL,
      ST_TRAIL,
      ST_DROP
   } stream_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } out_item_type;

   out_item_type     pending_out_bytes[$];
   cfg_type          cfg;
   logic [7:0]       hdr_mem [HEADER_BYTES];
   int               hdr_cnt;
   stream_state_type st;
   int               img_w;
   int               img_h;
   int               col;
   int               row;
   chan_type         chan;
   int               pad;

   initial fail_count = 0;
   initial pending_count = 0;

   function automatic out_item_type out_item(input logic [7:0] d, input logic l,
                                             input logic e);
      out_item_type it;
      it.data = d;
      it.last = l;
      it.err  = e;
      return it;
   endfunction

   function automatic int abs_rows();
      return img_h < 0 ? -img_h : img_h;
   endfunction

   function automatic void next_row();
      col  = 0;
      chan = CH_BLUE;
      row++;
      if (row >= abs_rows()) begin
         st = ST_TRAIL;
      end
   endfunction

   // Truncating Q8.8 multiply, negative products floor at zero.
   function automatic logic [7:0] apply_gain(input logic [7:0] v,
                                             input logic signed [GAIN_W-1:0] g);
      int p;
      int q;
      p = int'(v) * int'(g);
      if (p < 0) begin
         return 8'd0;
      end
      q = p >>> 8;
      return q > 255 ? 8'd255 : q[7:0];
   endfunction

   function automatic logic [7:0] gain_pixel(input logic [7:0] v);
      int ah, lft, top, rgt, bot, x1, y1, x2, y2, ay;
      logic signed [GAIN_W-1:0] g;
      logic [7:0] r;
      ah  = abs_rows();
      lft = int'($signed(cfg.rect_left));
      top = int'($signed(cfg.rect_top));
      rgt = int'($signed(cfg.rect_right));
      bot = int'($signed(cfg.rect_bottom));
      x1  = lft < 0 ? 0 : lft;
      y1  = top < 0 ? 0 : top;
      x2  = rgt >= img_w ? img_w - 1 : rgt;
      y2  = bot >= ah ? ah - 1 : bot;
      // Rows arrive bottom-up when the height is positive.
      ay  = img_h > 0 ? ah - 1 - row : row;
      r   = v;
      if (col >= x1 && col <= x2 && ay >= y1 && ay <= y2) begin
         g = (chan == CH_BLUE) ? cfg.gain_blue :
             (chan == CH_GREEN) ? cfg.gain_green : cfg.gain_red;
         r = apply_gain(v, g);
      end
      if (chan == CH_RED) begin
         chan = CH_BLUE;
         col++;
         if (col >= img_w) begin
            pad = (4 - (img_w * 3) % 4) % 4;
            if (pad == 0) begin
               next_row();
            end
         end
      end else begin
         chan = (chan == CH_BLUE) ? CH_GREEN : CH_RED;
      end
      return r;
   endfunction

   task automatic scale_stream_byte(input logic [7:0] b, input logic fe);
      longint w, h, ah;
      logic [15:0] depth;
      logic [7:0] r;
      int k;
      if (st == ST_HEADER) begin
         if (hdr_cnt >= HEADER_BYTES) begin
            hdr_cnt = 0;
         end
         hdr_mem[hdr_cnt] = b;
         hdr_cnt++;
         if (hdr_cnt >= HEADER_BYTES) begin
            w = longint'($signed({hdr_mem[OFS_WIDTH+3], hdr_mem[OFS_WIDTH+2],
                                  hdr_mem[OFS_WIDTH+1], hdr_mem[OFS_WIDTH]}));
            h = longint'($signed({hdr_mem[OFS_HEIGHT+3], hdr_mem[OFS_HEIGHT+2],
                                  hdr_mem[OFS_HEIGHT+1], hdr_mem[OFS_HEIGHT]}));
            depth = {hdr_mem[OFS_DEPTH+1], hdr_mem[OFS_DEPTH]};
            ah = h < 0 ? -h : h;
            hdr_cnt = 0;
            if (depth != DEPTH_OK || w < 0 || w > MAX_DIM || ah > MAX_DIM) begin
               pending_out_bytes.push_back(out_item(8'h00, 1'b1, 1'b1));
               st = ST_DROP;
            end else begin
               for (k = 0; k < HEADER_BYTES; k++) begin
                  pending_out_bytes.push_back(out_item(hdr_mem[k], k == HEADER_BYTES - 1,
                                                       1'b0));
               end
               img_w = int'(w);
               img_h = int'(h);
               col   = 0;
               row   = 0;
               chan  = CH_BLUE;
               pad   = 0;
               st    = (w == 0 || h == 0) ? ST_TRAIL : ST_PIXEL;
            end
         end else if (fe) begin
            pending_out_bytes.push_back(out_item(8'h00, 1'b1, 1'b1));
         end
      end else if (st == ST_PIXEL) begin
         r = b;
         if (pad > 0) begin
            pad--;
            if (pad == 0) begin
               next_row();
            end
         end else begin
            r = gain_pixel(b);
         end
         pending_out_bytes.push_back(out_item(r, 1'b1, 1'b0));
      end else if (st == ST_TRAIL) begin
         pending_out_bytes.push_back(out_item(b, 1'b1, 1'b0));
      end
      if (fe) begin
         st      = ST_HEADER;
         hdr_cnt = 0;
         pad     = 0;
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      out_item_type want;
      if (reset) begin
         cfg     = CFG_RESET;
         hdr_cnt = 0;
         st      = ST_HEADER;
         img_w   = 0;
         img_h   = 0;
         col     = 0;
         row     = 0;
         chan    = CH_BLUE;
         pad     = 0;
         pending_out_bytes.delete();
      end else begin
         // An item popped now cannot stem from a byte pushed at this same edge.
         if (!empty && pop) begin
            if (pending_out_bytes.size() == 0) begin
               $display("%0t: unexpected item, actual byte %02h last %0b error %0b",
                        $time, rsp_out_byte, rsp_run_last, rsp_format_error);
               fail_count++;
            end else begin
               want = pending_out_bytes.pop_front();
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("run_last", want.last, rsp_run_last);
               check_field("format_error", want.err, rsp_format_error);
            end
         end
         if (push && !full) begin
            scale_stream_byte(req_in_byte, req_file_end);
         end
         if (csr_we) begin
            case (reg_index_type'(csr_addr))
               REG_RECT_LEFT:   cfg.rect_left   = csr_wdata[RECT_W-1:0];
               REG_RECT_TOP:    cfg.rect_top    = csr_wdata[RECT_W-1:0];
               REG_RECT_RIGHT:  cfg.rect_right  = csr_wdata[RECT_W-1:0];
               REG_RECT_BOTTOM: cfg.rect_bottom = csr_wdata[RECT_W-1:0];
               REG_GAIN_RED:    cfg.gain_red    = csr_wdata[GAIN_W-1:0];
               REG_GAIN_GREEN:  cfg.gain_green  = csr_wdata[GAIN_W-1:0];
               REG_GAIN_BLUE:   cfg.gain_blue   = csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= pending_out_bytes.size();
   end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Testbench top for the BMP region gain core. This module only makes stimulus and gives
// the verdict; prediction and comparison live in the checker instantiated beside the
// block. The stimulus is a sequence of small BMP files fed one byte per item.
module tb_top;
   import brg_pkg::*;

   // The run is far shorter than this; reaching it means the block hung.
   localparam int LIMIT_CYCLES = 400000;
   // Long receiver hold-off used to fill the block and stall its input queue.
   localparam int HOLD_CYCLES = 400;
   // Random bytes offered in each idling phase before that phase stops.
   localparam int RANDOM_BYTES_PER_PHASE = 130;
   // Cycles allowed after the last expected item for the pipeline to settle.
   localparam int SETTLE_CYCLES = 12;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 push             = 1'b0;
   logic                 full;
   logic [7:0]           req_in_byte      = 8'h00;
   logic                 req_file_end     = 1'b0;
   logic                 empty;
   logic                 pop              = 1'b0;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_run_last;
   logic                 rsp_format_error;
   logic                 csr_we           = 1'b0;
   logic [REG_IDX_W-1:0] csr_addr         = '0;
   logic [CSR_W-1:0]     csr_wdata        = '0;

   int fail_count;
   int pending_count;

   // Idling rates in percent, the hold-off handshake and the run bookkeeping.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_reqs     = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int n_sent        = 0;
   int cycle_cnt     = 0;

   logic [7:0] file_q[$];

   bmp_region_rgb_gain_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .req_file_end     (req_file_end),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_format_error (rsp_format_error),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   bmp_region_rgb_gain_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .req_file_end     (req_file_end),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_format_error (rsp_format_error),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung block must still end the run with a verdict.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver. A new hold-off request keeps pop low until the HOLD_CYCLES count has run
   // out; otherwise pop is drawn each cycle from the current idling rate.
   always @(posedge clock) begin
      if (hold_seen != hold_reqs) begin
         hold_seen <= hold_reqs;
         hold_left <= HOLD_CYCLES;
         pop       <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one byte, idling first at the sender's rate, and wait until it is taken.
   // push stays high afterwards so back-to-back items need no extra assignment.
   task automatic send_byte(input logic [7:0] b, input logic fe);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push         <= 1'b1;
      req_in_byte  <= b;
      req_file_end <= fe;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      n_sent++;
   endtask

   // Stop offering items and wait until every predicted item has been popped. The first
   // edge lets the checker's count catch up with a byte taken at the previous edge.
   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   // Registers change only on an idle block, so drain and let the pipeline settle.
   task automatic wait_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_cfg(input cfg_type c);
      write_reg(REG_RECT_LEFT, CSR_W'(c.rect_left));
      write_reg(REG_RECT_TOP, CSR_W'(c.rect_top));
      write_reg(REG_RECT_RIGHT, CSR_W'(c.rect_right));
      write_reg(REG_RECT_BOTTOM, CSR_W'(c.rect_bottom));
      write_reg(REG_GAIN_RED, c.gain_red);
      write_reg(REG_GAIN_GREEN, c.gain_green);
      write_reg(REG_GAIN_BLUE, c.gain_blue);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [RECT_W-1:0] rand_rect();
      case ($urandom_range(9))
         0:       return RECT_W'(-4096);
         1:       return RECT_W'(RECT_MAX);
         2:       return RECT_W'($urandom);
         default: return RECT_W'(int'($urandom_range(0, 9)) - 2);
      endcase
   endfunction

   function automatic logic signed [GAIN_W-1:0] rand_gain();
      case ($urandom_range(9))
         0:       return GAIN_W'(GAIN_UNITY);
         1:       return GAIN_W'(-32768);
         2:       return GAIN_W'(32767);
         3:       return GAIN_W'(0);
         4, 5:    return GAIN_W'($urandom);
         default: return GAIN_W'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic cfg_type rand_cfg();
      cfg_type c;
      c.rect_left   = rand_rect();
      c.rect_top    = rand_rect();
      c.rect_right  = rand_rect();
      c.rect_bottom = rand_rect();
      c.gain_red    = rand_gain();
      c.gain_green  = rand_gain();
      c.gain_blue   = rand_gain();
      return c;
   endfunction

   // Pixel data size of a well-formed image: rows of 3*w bytes padded to four.
   function automatic int frame_bytes(input int w, input int h);
      int rows;
      rows = h < 0 ? -h : h;
      return (w * 3 + (4 - (w * 3) % 4) % 4) * rows;
   endfunction

   // Send one file: a 54-byte header with random filler and the given width, height
   // and depth, then n_body random bytes, with file_end on the very last byte. Body
   // bytes lean toward 0 and 255 so that saturation is hit often. When pause_at is not
   // negative the sender stops before that byte until every expected item has come.
   task automatic send_image(input longint w, input longint h, input int depth,
                             input int n_body, input int pause_at);
      logic [31:0] w32;
      logic [31:0] h32;
      int i;
      w32 = w[31:0];
      h32 = h[31:0];
      file_q.delete();
      for (i = 0; i < HEADER_BYTES; i++) begin
         file_q.push_back(8'($urandom));
      end
      for (i = 0; i < FIELD_BYTES; i++) begin
         file_q[OFS_WIDTH + i]  = w32[8*i +: 8];
         file_q[OFS_HEIGHT + i] = h32[8*i +: 8];
      end
      file_q[OFS_DEPTH]     = depth[7:0];
      file_q[OFS_DEPTH + 1] = depth[15:8];
      for (i = 0; i < n_body; i++) begin
         case ($urandom_range(7))
            0:       file_q.push_back(8'h00);
            1:       file_q.push_back(8'hFF);
            default: file_q.push_back(8'($urandom));
         endcase
      end
      for (i = 0; i < file_q.size(); i++) begin
         if (i == pause_at) begin
            wait_drained();
         end
         send_byte(file_q[i], i == file_q.size() - 1);
      end
   endtask

   // A file that ends before its header is complete.
   task automatic send_short_header(input int len);
      int i;
      for (i = 1; i <= len; i++) begin
         send_byte(8'($urandom), i == len);
      end
   endtask

   initial begin
      cfg_type c;
      int phase_no;
      int phase_start;
      int kind;
      int w;
      int h;
      int n;
      int depth;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The first file runs with the reset values of every register.
      send_image(2, 2, BMP_DEPTH, frame_bytes(2, 2) + 1, -1);

      // Region covers everything; red and green gains at the extremes of the Q8.8 range.
      wait_idle();
      c = '{rect_left: RECT_W'(-4096), rect_top: RECT_W'(-4096),
            rect_right: RECT_W'(RECT_MAX), rect_bottom: RECT_W'(RECT_MAX),
            gain_red: GAIN_W'(32767), gain_green: GAIN_W'(-32768),
            gain_blue: GAIN_W'(128)};
      write_cfg(c);
      send_image(3, 2, BMP_DEPTH, frame_bytes(3, 2) + 2, -1);

      // A single-pixel region, seen once top-down and once bottom-up.
      wait_idle();
      c = '{rect_left: RECT_W'(0), rect_top: RECT_W'(1), rect_right: RECT_W'(0),
            rect_bottom: RECT_W'(1), gain_red: GAIN_W'(512), gain_green: GAIN_W'(256),
            gain_blue: GAIN_W'(0)};
      write_cfg(c);
      send_image(1, -3, BMP_DEPTH, frame_bytes(1, -3), -1);
      send_image(5, 4, BMP_DEPTH, frame_bytes(5, 4) + 1, -1);

      // Empty rectangle: left beyond right and top beyond bottom, so nothing changes.
      wait_idle();
      c = '{rect_left: RECT_W'(3), rect_top: RECT_W'(2), rect_right: RECT_W'(1),
            rect_bottom: RECT_W'(0), gain_red: GAIN_W'(0), gain_green: GAIN_W'(0),
            gain_blue: GAIN_W'(0)};
      write_cfg(c);
      send_image(2, 1, BMP_DEPTH, frame_bytes(2, 1) + 2, -1);

      // Empty images: zero width, then zero height. All body bytes pass through.
      send_image(0, 5, BMP_DEPTH, 3, -1);
      send_image(4, 0, BMP_DEPTH, 2, -1);

      // Bad formats: wrong depth, negative or oversized width, oversized height of
      // either sign and the most negative height. Trailing bytes are dropped.
      send_image(2, 2, 32, 5, -1);
      send_image(-1, 2, BMP_DEPTH, 3, -1);
      send_image(MAX_DIM + 1, 2, BMP_DEPTH, 2, -1);
      send_image(2, MAX_DIM + 1, BMP_DEPTH, 2, -1);
      send_image(2, -(MAX_DIM + 1), BMP_DEPTH, 1, -1);
      send_image(3, -2147483648, BMP_DEPTH, 2, -1);

      // The largest legal sizes, cut short inside the pixel data, with a region and
      // large gains that reach the first rows.
      wait_idle();
      c = '{rect_left: RECT_W'(0), rect_top: RECT_W'(0), rect_right: RECT_W'(RECT_MAX),
            rect_bottom: RECT_W'(RECT_MAX), gain_red: GAIN_W'(1024),
            gain_green: GAIN_W'(300), gain_blue: GAIN_W'(-5)};
      write_cfg(c);
      send_image(MAX_DIM, -MAX_DIM, BMP_DEPTH, 30, -1);
      send_image(MAX_DIM, MAX_DIM, BMP_DEPTH, 12, -1);

      // Short headers, and a file that is nothing but a good header.
      send_short_header(10);
      send_short_header(HEADER_BYTES - 1);
      send_image(2, 2, BMP_DEPTH, 0, -1);

      // Back pressure: the receiver holds off for a long stretch while a full image is
      // offered, so the block fills and raises full; later the sender pauses until
      // every expected item has come.
      wait_idle();
      c = '{rect_left: RECT_W'(1), rect_top: RECT_W'(0), rect_right: RECT_W'(2),
            rect_bottom: RECT_W'(1), gain_red: rand_gain(), gain_green: rand_gain(),
            gain_blue: rand_gain()};
      write_cfg(c);
      hold_reqs <= hold_reqs + 1;
      send_image(4, 4, BMP_DEPTH, frame_bytes(4, 4), HEADER_BYTES + 26);

      // Random part in three idling phases: a slow receiver, then a slow sender, then
      // neither idling. Most files are well formed with random content and geometry.
      for (phase_no = 0; phase_no < 3; phase_no++) begin
         send_idle_pct <= (phase_no == 0) ? 28 : (phase_no == 1) ? 81 : 0;
         recv_idle_pct <= (phase_no == 0) ? 81 : (phase_no == 1) ? 28 : 0;
         phase_start = n_sent;
         while (n_sent - phase_start < RANDOM_BYTES_PER_PHASE) begin
            if ($urandom_range(9) < 3) begin
               wait_idle();
               write_cfg(rand_cfg());
            end
            kind = $urandom_range(99);
            w = $urandom_range(0, 5);
            h = $urandom_range(0, 4);
            if ($urandom_range(1) == 1) begin
               h = -h;
            end
            depth = BMP_DEPTH;
            if (kind < 10) begin
               send_short_header($urandom_range(1, HEADER_BYTES - 1));
            end else if (kind < 22) begin
               case ($urandom_range(3))
                  0: begin
                     depth = $urandom_range(0, 65535);
                     if (depth == BMP_DEPTH) begin
                        depth = 8;
                     end
                  end
                  1: w = -int'($urandom_range(1, 100000));
                  2: w = MAX_DIM + $urandom_range(1, 5000);
                  default: begin
                     h = MAX_DIM + $urandom_range(1, 5000);
                     if ($urandom_range(1) == 1) begin
                        h = -h;
                     end
                  end
               endcase
               send_image(w, h, depth, $urandom_range(0, 6), -1);
            end else begin
               n = frame_bytes(w, h);
               if ($urandom_range(9) < 2) begin
                  n = $urandom_range(0, n);
               end else begin
                  n = n + $urandom_range(0, 3);
               end
               send_image(w, h, depth, n, -1);
            end
         end
      end

      // Drain, give the block time to show any stray item, then the verdict.
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/brg_pkg.sv
design/brg_front.sv
design/brg_cmd_fifo.sv
design/brg_back.sv
design/bmp_region_rgb_gain_core.sv
verif/bmp_region_rgb_gain_checker.sv
verif/tb_top.sv
